/* hw/rtl/bbs_pkg.sv */
// Shared types and constants of the bright blob steering block.
`timescale 1ns / 1ps
`default_nettype none
package bbs_pkg;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 23;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_FAR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_NEAR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd5;

	localparam logic [14:0] RST_SPEED_MAX = 15'd2048;
	localparam logic [15:0] RST_SPEED_MIN = 16'd0;
	localparam logic [14:0] RST_TURN_MAX = 15'd4096;
	localparam logic [22:0] RST_AREA_FAR = 23'd140000;
	localparam logic [22:0] RST_AREA_NEAR = 23'd1200;
	localparam logic [11:0] RST_IMAGE_WIDTH = 12'd640;
	localparam logic [11:0] MIN_WIDTH = 12'd2;

	// gray conversion, 14 bit weights
	localparam logic [22:0] GRAY_B_COEF = 23'd1868;
	localparam logic [22:0] GRAY_G_COEF = 23'd9617;
	localparam logic [22:0] GRAY_R_COEF = 23'd4899;
	localparam logic [22:0] GRAY_ROUND = 23'd8192;
	localparam int GRAY_SHIFT = 14;
	localparam logic [8:0] WHITE_LEVEL = 9'd254;

	// limits
	localparam logic [23:0] AREA_FIELD_MAX = 24'hFFFFFF;
	localparam logic [35:0] SUM_MAX = 36'hFFFFFFFFF;
	localparam logic [11:0] CEN_MAX = 12'hFFF;

	// shared divider size
	localparam int NUM_W = 53;
	localparam int DEN_W = 36;

	// datapath operations
	typedef logic [3:0] op_t;
	localparam op_t OP_IDLE = 4'd0;
	localparam op_t OP_CEN_GO = 4'd1;
	localparam op_t OP_CEN_CAP = 4'd2;
	localparam op_t OP_LIN_MUL = 4'd3;
	localparam op_t OP_LIN_GO = 4'd4;
	localparam op_t OP_LIN_CAP = 4'd5;
	localparam op_t OP_ANG_MULW = 4'd6;
	localparam op_t OP_ANG_DIFF = 4'd7;
	localparam op_t OP_ANG_MLO = 4'd8;
	localparam op_t OP_ANG_MHI = 4'd9;
	localparam op_t OP_ANG_SUM = 4'd10;
	localparam op_t OP_ANG_GO = 4'd11;
	localparam op_t OP_ANG_CAP = 4'd12;
	localparam op_t OP_OUT = 4'd13;

	typedef struct packed {
		logic take;
		op_t op;
	} bbs_cmd_t;

	typedef struct packed {
		logic last_taken;
		logic area_zero;
		logic div_done;
		logic out_free;
	} bbs_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/bright_blob_steering_top.sv */
// Top level of the bright blob steering block.
//
// Pixel words enter on the s_ group, one per clock while s_tready is high:
// s_tdata carries blue, green, red (8 bits each, blue lowest), s_tlast marks
// the last pixel of a frame. Pixels whose gray level exceeds 254 count as
// white; the block sums their number and their column positions.
// After the word with s_tlast is taken, s_tready drops while the frame-end
// arithmetic runs: centroid, linear and angular velocity, each through one
// shared restoring divider of 53 quotient bits (one bit per cycle). The
// result word appears on m_tvalid once the three divisions are done; when no
// pixel was white the divisions are skipped.
// Within a frame the block takes one pixel every clock.
// The m_ group holds one result word in an output register: the next frame
// is taken while it waits. Should the receiver still hold off when the next
// frame's result is ready, the sequencer waits and s_tready stays low.
// The user writes the registers through cfg_we / cfg_index / cfg_data, only between
// frames; the block does not enforce it. Reset (arst_n low) restores register
// defaults, clears the frame sums and the column counter and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module bright_blob_steering_top #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [23:0]                    s_tdata,   // blue, green, red
	input  wire logic                           s_tlast,   // frame_end
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// linear_velocity, angular_velocity, centroid_col, blob_area, 4 zero bits
	output logic [71:0]                         m_tdata,
	output logic [0:0]                          m_tuser,   // ball_seen
	input  wire logic                           cfg_we,
	input  wire logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bbs_pkg::*;

	// area saturates at the frame size, or at the field's top if smaller
	localparam longint AREA_CAP = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
	localparam logic [23:0] AREA_LIMIT =
		(AREA_CAP < longint'(AREA_FIELD_MAX)) ? 24'(AREA_CAP) : AREA_FIELD_MAX;

	bbs_cmd_t  cmd;
	bbs_stat_t stat;

	bbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.cmd(cmd)
	);

	bbs_dp #(
		.AREA_LIMIT(AREA_LIMIT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	assign s_tready = cmd.take;

endmodule
`default_nettype wire

/* hw/rtl/bbs_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bbs_div #(
	parameter int NW = 53,
	parameter int DW = 36
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quo,
	output logic               done
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign quo = quo_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/bbs_ctrl.sv */
// Frame sequencer: pixel intake, then the frame-end arithmetic steps.
`timescale 1ns / 1ps
`default_nettype none
module bbs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bbs_pkg::bbs_stat_t stat,
	output bbs_pkg::bbs_cmd_t      cmd
);
	import bbs_pkg::*;

	localparam logic [3:0] ST_ACCUM = 4'd0;
	localparam logic [3:0] ST_DRAIN = 4'd1;
	localparam logic [3:0] ST_CEN_GO = 4'd2;
	localparam logic [3:0] ST_CEN_WAIT = 4'd3;
	localparam logic [3:0] ST_LIN_MUL = 4'd4;
	localparam logic [3:0] ST_LIN_GO = 4'd5;
	localparam logic [3:0] ST_LIN_WAIT = 4'd6;
	localparam logic [3:0] ST_ANG_MULW = 4'd7;
	localparam logic [3:0] ST_ANG_DIFF = 4'd8;
	localparam logic [3:0] ST_ANG_MLO = 4'd9;
	localparam logic [3:0] ST_ANG_MHI = 4'd10;
	localparam logic [3:0] ST_ANG_SUM = 4'd11;
	localparam logic [3:0] ST_ANG_GO = 4'd12;
	localparam logic [3:0] ST_ANG_WAIT = 4'd13;
	localparam logic [3:0] ST_OUT = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd.take = 1'b0;
		cmd.op = OP_IDLE;
		case (state_q)
			ST_ACCUM: begin
				cmd.take = 1'b1;
				if (stat.last_taken) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_CEN_GO;
			ST_CEN_GO: begin
				if (stat.area_zero) begin
					state_d = ST_OUT;
				end else begin
					cmd.op = OP_CEN_GO;
					state_d = ST_CEN_WAIT;
				end
			end
			ST_CEN_WAIT: begin
				if (stat.div_done) begin
					cmd.op = OP_CEN_CAP;
					state_d = ST_LIN_MUL;
				end
			end
			ST_LIN_MUL: begin
				cmd.op = OP_LIN_MUL;
				state_d = ST_LIN_GO;
			end
			ST_LIN_GO: begin
				cmd.op = OP_LIN_GO;
				state_d = ST_LIN_WAIT;
			end
			ST_LIN_WAIT: begin
				if (stat.div_done) begin
					cmd.op = OP_LIN_CAP;
					state_d = ST_ANG_MULW;
				end
			end
			ST_ANG_MULW: begin
				cmd.op = OP_ANG_MULW;
				state_d = ST_ANG_DIFF;
			end
			ST_ANG_DIFF: begin
				cmd.op = OP_ANG_DIFF;
				state_d = ST_ANG_MLO;
			end
			ST_ANG_MLO: begin
				cmd.op = OP_ANG_MLO;
				state_d = ST_ANG_MHI;
			end
			ST_ANG_MHI: begin
				cmd.op = OP_ANG_MHI;
				state_d = ST_ANG_SUM;
			end
			ST_ANG_SUM: begin
				cmd.op = OP_ANG_SUM;
				state_d = ST_ANG_GO;
			end
			ST_ANG_GO: begin
				cmd.op = OP_ANG_GO;
				state_d = ST_ANG_WAIT;
			end
			ST_ANG_WAIT: begin
				if (stat.div_done) begin
					cmd.op = OP_ANG_CAP;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold here while the previous result is still unclaimed
				if (stat.out_free) begin
					cmd.op = OP_OUT;
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/bbs_dp.sv */
// Datapath: registers, pixel accumulation, steering arithmetic, result register.
`timescale 1ns / 1ps
`default_nettype none
module bbs_dp #(
	parameter logic [23:0] AREA_LIMIT = 24'hFFFFFF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bbs_pkg::bbs_cmd_t              cmd,
	output bbs_pkg::bbs_stat_t                  stat,
	input  wire logic                           cfg_we,
	input  wire logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bbs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           s_tvalid,
	input  wire logic [23:0]                    s_tdata,
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [71:0]                         m_tdata,
	output logic [0:0]                          m_tuser
);
	import bbs_pkg::*;

	// registers
	logic [14:0]        speed_max_q;
	logic signed [15:0] speed_min_q;
	logic [14:0]        turn_max_q;
	logic [22:0]        area_far_q;
	logic [22:0]        area_near_q;
	logic [11:0]        width_q;
	logic [11:0]        w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_max_q <= RST_SPEED_MAX;
			speed_min_q <= RST_SPEED_MIN;
			turn_max_q <= RST_TURN_MAX;
			area_far_q <= RST_AREA_FAR;
			area_near_q <= RST_AREA_NEAR;
			width_q <= RST_IMAGE_WIDTH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPEED_MAX: speed_max_q <= cfg_data[14:0];
				CFG_SPEED_MIN: speed_min_q <= cfg_data[15:0];
				CFG_TURN_MAX: turn_max_q <= cfg_data[14:0];
				CFG_AREA_FAR: area_far_q <= cfg_data[22:0];
				CFG_AREA_NEAR: area_near_q <= cfg_data[22:0];
				CFG_IMAGE_WIDTH: width_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q < MIN_WIDTH) ? MIN_WIDTH : width_q;

	// pixel intake
	logic        pix_take;
	logic [22:0] wsum;
	logic [8:0]  gray;
	logic [11:0] col_q;
	logic [12:0] col_inc;
	logic        valid_s1;
	logic        white_s1;
	logic [11:0] col_s1;

	assign pix_take = s_tvalid & cmd.take;
	assign wsum = GRAY_B_COEF * 23'(s_tdata[7:0]) + GRAY_G_COEF * 23'(s_tdata[15:8])
		+ GRAY_R_COEF * 23'(s_tdata[23:16]) + GRAY_ROUND;
	assign gray = wsum[GRAY_SHIFT+8:GRAY_SHIFT];
	assign col_inc = {1'b0, col_q} + 13'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pix_take;
			if (pix_take) begin
				if (s_tlast || col_inc >= {1'b0, w_eff}) col_q <= '0;
				else col_q <= col_inc[11:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take) begin
			white_s1 <= gray > WHITE_LEVEL;
			col_s1 <= col_q;
		end
	end

	// frame accumulators
	logic [23:0] area_q;
	logic [35:0] sum_q;
	logic [36:0] sum_inc;

	assign sum_inc = {1'b0, sum_q} + 37'(col_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
			sum_q <= '0;
		end else if (cmd.op == OP_OUT) begin
			area_q <= '0;
			sum_q <= '0;
		end else if (valid_s1 && white_s1) begin
			if (area_q < AREA_LIMIT) area_q <= area_q + 24'd1;
			sum_q <= sum_inc[36] ? SUM_MAX : sum_inc[35:0];
		end
	end

	// steering arithmetic
	logic [NUM_W-1:0] num_q;
	logic             neg_q;
	logic [35:0]      denw_q;
	logic [36:0]      mag_q;
	logic [27:0]      hi_q;
	logic [11:0]      cen_q;
	logic [15:0]      lin_q;
	logic [15:0]      ang_q;

	logic signed [24:0] lin_diff;
	logic [23:0]        lin_mag;
	logic [22:0]        lin_den;
	logic [37:0]        ang_diff;
	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [NUM_W-1:0]   quo;
	logic               div_done;

	assign lin_diff = $signed({2'b00, area_far_q}) - $signed({1'b0, area_q});
	assign lin_mag = lin_diff[24] ? 24'(-lin_diff) : lin_diff[23:0];
	assign lin_den = area_far_q - area_near_q;
	assign ang_diff = {2'b00, denw_q} - {1'b0, sum_q, 1'b0};

	always_comb begin
		div_start = 1'b0;
		div_num = NUM_W'(sum_q);
		div_den = DEN_W'(area_q);
		case (cmd.op)
			OP_CEN_GO: div_start = 1'b1;
			OP_LIN_GO: begin
				div_start = 1'b1;
				div_num = num_q + NUM_W'(lin_den >> 1);
				div_den = DEN_W'(lin_den);
			end
			OP_ANG_GO: begin
				div_start = 1'b1;
				div_num = num_q + NUM_W'(denw_q >> 1);
				div_den = denw_q;
			end
			default: ;
		endcase
	end

	bbs_div #(
		.NW(NUM_W),
		.DW(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quo(quo),
		.done(div_done)
	);

	// signed quotient and the clamp bounds at a common width
	logic signed [NUM_W:0] q_signed;
	logic signed [NUM_W:0] smax_w;
	logic signed [NUM_W:0] smin_w;
	logic signed [NUM_W:0] tmax_w;
	logic signed [NUM_W:0] tmin_w;
	logic signed [NUM_W:0] lin_hi;
	logic signed [NUM_W:0] lin_cl;
	logic signed [NUM_W:0] ang_cl;

	always_comb begin
		q_signed = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		smax_w = (NUM_W+1)'($signed({1'b0, speed_max_q}));
		smin_w = (NUM_W+1)'(speed_min_q);
		tmax_w = (NUM_W+1)'($signed({1'b0, turn_max_q}));
		tmin_w = -tmax_w;
		lin_hi = (q_signed > smax_w) ? smax_w : q_signed;
		lin_cl = (lin_hi < smin_w) ? smin_w : lin_hi;
		ang_cl = (q_signed > tmax_w) ? tmax_w : ((q_signed < tmin_w) ? tmin_w : q_signed);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CEN_CAP: cen_q <= (quo > NUM_W'(CEN_MAX)) ? CEN_MAX : quo[11:0];
			OP_LIN_MUL: begin
				num_q <= NUM_W'(39'(speed_max_q) * 39'(lin_mag));
				neg_q <= lin_diff[24];
			end
			OP_LIN_CAP: begin
				// an empty area span pins the speed to its floor
				if (area_far_q <= area_near_q) lin_q <= speed_min_q;
				else lin_q <= lin_cl[15:0];
			end
			OP_ANG_MULW: denw_q <= 36'(w_eff) * 36'(area_q);
			OP_ANG_DIFF: begin
				neg_q <= ang_diff[37];
				mag_q <= ang_diff[37] ? 37'(-ang_diff) : ang_diff[36:0];
			end
			OP_ANG_MLO: num_q <= NUM_W'(39'(turn_max_q) * 39'(mag_q[23:0]));
			OP_ANG_MHI: hi_q <= 28'(turn_max_q) * 28'(mag_q[36:24]);
			OP_ANG_SUM: num_q <= num_q + (NUM_W'(hi_q) << 24);
			OP_ANG_CAP: ang_q <= ang_cl[15:0];
			default: ;
		endcase
	end

	// result register
	logic        out_valid_q;
	logic [71:0] out_data_q;
	logic        out_seen_q;
	logic        seen;

	assign seen = area_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_seen_q <= seen;
			out_data_q <= {4'b0000, area_q, seen ? cen_q : 12'd0,
				seen ? ang_q : 16'd0, seen ? lin_q : 16'd0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_seen_q;

	assign stat.last_taken = pix_take & s_tlast;
	assign stat.area_zero = ~seen;
	assign stat.div_done = div_done;
	assign stat.out_free = ~out_valid_q | m_tready;

endmodule
`default_nettype wire

/* test/bbs_steer_checker.sv */
// Checker for the steering block: predicts each frame's result word and compares it.
`timescale 1ns / 1ps
module bbs_steer_checker #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [23:0]                    s_tdata,   // blue, green, red
	input  wire logic                           s_tlast,   // frame_end
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	// linear_velocity, angular_velocity, centroid_col, blob_area, 4 zero bits
	input  wire logic [71:0]                    m_tdata,
	input  wire logic [0:0]                     m_tuser,   // ball_seen
	input  wire logic                           cfg_we,
	input  wire logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  pending,
	output int                                  fail_count
);

	localparam longint WEIGHT_B = 1868;
	localparam longint WEIGHT_G = 9617;
	localparam longint WEIGHT_R = 4899;
	localparam longint GRAY_HALF = 8192;
	localparam longint WHITE_ABOVE = 254;
	localparam longint SUM_CAP = 64'hF_FFFF_FFFF;
	localparam longint AREA_FIELD_CAP = 64'hFF_FFFF;
	localparam longint AREA_PRODUCT = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
	localparam longint AREA_CAP = (AREA_PRODUCT < AREA_FIELD_CAP) ? AREA_PRODUCT : AREA_FIELD_CAP;

	typedef struct packed {
		logic               seen;
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		logic [11:0]        cen;
		logic [23:0]        area;
	} steer_t;

	// register copies
	logic [14:0]        speed_top;
	logic signed [15:0] speed_floor;
	logic [14:0]        turn_top;
	logic [22:0]        far_area;
	logic [22:0]        near_area;
	logic [11:0]        row_width;

	// running frame sums
	logic [11:0] col;
	longint      white_n;
	longint      col_total;

	steer_t expected_q[$];
	int     errs = 0;

	function automatic longint eff_width();
		return (row_width < 12'd2) ? 64'd2 : longint'(row_width);
	endfunction

	// nearest, halves away from zero
	function automatic longint round_quot(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic steer_t steer_from(longint area, longint sum);
		steer_t res;
		longint w, cen, lin, ang, den, top, bottom, turn, fa, na;
		res = '0;
		if (area == 0)
			return res;
		w = eff_width();
		top = speed_top;
		bottom = speed_floor;
		turn = turn_top;
		fa = far_area;
		na = near_area;
		cen = sum / area;
		if (cen > 4095)
			cen = 4095;
		if (fa <= na) begin
			lin = bottom;
		end else begin
			lin = round_quot(top * (fa - area), fa - na);
			if (lin > top)
				lin = top;
			if (lin < bottom)
				lin = bottom;
		end
		den = w * area;
		ang = round_quot(turn * (den - 2 * sum), den);
		if (ang > turn)
			ang = turn;
		if (ang < -turn)
			ang = -turn;
		res.seen = 1'b1;
		res.lin = lin[15:0];
		res.ang = ang[15:0];
		res.cen = cen[11:0];
		res.area = area[23:0];
		return res;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		steer_t got;
		steer_t want;
		longint gray;
		if (!arst_n) begin
			speed_top = 15'd2048;
			speed_floor = 16'sd0;
			turn_top = 15'd4096;
			far_area = 23'd140000;
			near_area = 23'd1200;
			row_width = 12'd640;
			col = '0;
			white_n = 0;
			col_total = 0;
			expected_q.delete();
			pending <= 0;
			fail_count <= errs;
		end else begin
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					bbs_pkg::CFG_SPEED_MAX:   speed_top = cfg_data[14:0];
					bbs_pkg::CFG_SPEED_MIN:   speed_floor = cfg_data[15:0];
					bbs_pkg::CFG_TURN_MAX:    turn_top = cfg_data[14:0];
					bbs_pkg::CFG_AREA_FAR:    far_area = cfg_data[22:0];
					bbs_pkg::CFG_AREA_NEAR:   near_area = cfg_data[22:0];
					bbs_pkg::CFG_IMAGE_WIDTH: row_width = cfg_data[11:0];
					default: ;
				endcase
			end

			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got.seen = m_tuser[0];
				got.lin = m_tdata[15:0];
				got.ang = m_tdata[31:16];
				got.cen = m_tdata[43:32];
				got.area = m_tdata[67:44];
				if (expected_q.size() == 0) begin
					$error("result word with no frame waiting for it");
					errs++;
				end else begin
					want = expected_q.pop_front();
					check_field("ball_seen", want.seen, got.seen);
					check_field("linear_velocity", want.lin, got.lin);
					check_field("angular_velocity", want.ang, got.ang);
					check_field("centroid_col", want.cen, got.cen);
					check_field("blob_area", want.area, got.area);
					check_field("padding", 0, m_tdata[71:68]);
				end
			end

			if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
				gray = (WEIGHT_B * s_tdata[7:0] + WEIGHT_G * s_tdata[15:8]
					+ WEIGHT_R * s_tdata[23:16] + GRAY_HALF) >> 14;
				if (gray > WHITE_ABOVE) begin
					if (white_n < AREA_CAP)
						white_n++;
					col_total = col_total + longint'(col);
					if (col_total > SUM_CAP)
						col_total = SUM_CAP;
				end
				if (longint'(col) + 1 >= eff_width())
					col = '0;
				else
					col = col + 12'd1;
				if (s_tlast === 1'b1) begin
					expected_q.push_back(steer_from(white_n, col_total));
					col = '0;
					white_n = 0;
					col_total = 0;
				end
			end

			pending <= expected_q.size();
			fail_count <= errs;
		end
	end

endmodule

/* test/tb.sv */
// Testbench top: pixel frames and register settings into the steering block, plus verdict.
`timescale 1ns / 1ps
module tb;
	import bbs_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 200;    // covers the frame-end arithmetic
	localparam int SQUEEZE_CYCLES = 1500;  // long receiver hold-off
	localparam int PHASES = 11;
	localparam int PHASE_WORDS = 60;
	localparam int SQUEEZE_PHASE = 4;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [71:0]           m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SPEED_MAX;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int pending;
	int fail_count;
	int cycles = 0;
	int words_sent = 0;
	int frames_sent = 0;
	int results_taken = 0;
	int settings_applied = 0;
	bit tx_burst = 1'b0;       // sender offers back to back when set
	logic squeeze = 1'b0;      // asks the receiver for its long hold-off

	bright_blob_steering_top #(
		.MAX_WIDTH(4096),
		.MAX_HEIGHT(2048)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bbs_steer_checker #(
		.MAX_WIDTH(4096),
		.MAX_HEIGHT(2048)
	) steer_chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.fail_count(fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side. Random stall per word, a stall-free stretch every 24 words,
	// and one long hold-off on request so the output register fills and the
	// block has to refuse pixels.
	initial begin : result_sink
		int gap;
		bit squeezed;
		squeezed = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze === 1'b1 && !squeezed) begin
				squeezed = 1'b1;
				gap = SQUEEZE_CYCLES;
			end else if (results_taken % 24 < 8) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 11);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			results_taken++;
		end
	end

	// One pixel word; returns at the edge that took it. Valid only drops when
	// a gap is drawn, so it is never lowered and raised in one step.
	task automatic send_word(input logic [7:0] blue, input logic [7:0] green,
			input logic [7:0] red, input logic last);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {red, green, blue};
		s_tlast <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		words_sent++;
	endtask

	// Near-white pixels sit around the threshold: a green step down is never
	// white, a red step down is, blue tolerates four.
	task automatic send_frame(input int len, input int white_pct);
		logic [23:0] px;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(1, 100) <= white_pct) begin
				px[23:16] = 8'd255 - 8'($urandom_range(0, 2));
				px[15:8] = ($urandom_range(0, 3) == 0) ? 8'd254 : 8'd255;
				px[7:0] = 8'd255 - 8'($urandom_range(0, 5));
			end else begin
				px = 24'($urandom());
			end
			send_word(px[7:0], px[15:8], px[23:16], i == len - 1);
		end
		frames_sent++;
	endtask

	// Stop offering, wait for every result, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [14:0] smax, input logic [15:0] smin,
			input logic [14:0] tmax, input logic [22:0] far_a, input logic [22:0] near_a,
			input logic [11:0] width);
		logic [CFG_DATA_W-1:0] val [6];
		logic [CFG_IDX_W-1:0]  idx [6];
		idx[0] = CFG_SPEED_MAX;
		val[0] = {8'd0, smax};
		idx[1] = CFG_SPEED_MIN;
		val[1] = {7'd0, smin};
		idx[2] = CFG_TURN_MAX;
		val[2] = {8'd0, tmax};
		idx[3] = CFG_AREA_FAR;
		val[3] = far_a;
		idx[4] = CFG_AREA_NEAR;
		val[4] = near_a;
		idx[5] = CFG_IMAGE_WIDTH;
		val[5] = {11'd0, width};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// First phases pin the extremes, the rest are random with small area
	// spans and mostly narrow rows so velocities and column wrap move a lot.
	task automatic phase_settings(input int p);
		logic [14:0] smax;
		logic [14:0] tmax;
		logic [15:0] smin;
		logic [22:0] far_a;
		logic [22:0] near_a;
		logic [11:0] width;
		case (p)
			0: begin
				// everything but the near area at its top, most negative floor
				smax = 15'h7FFF;
				smin = 16'h8000;
				tmax = 15'h7FFF;
				far_a = 23'h7FFFFF;
				near_a = '0;
				width = 12'hFFF;
			end
			1: begin
				// all zero: empty area span and a width below the minimum
				smax = '0;
				smin = '0;
				tmax = '0;
				far_a = '0;
				near_a = '0;
				width = '0;
			end
			2: begin
				// far below near, top floor, width of one
				smax = 15'd100;
				smin = 16'h7FFF;
				tmax = 15'd1;
				far_a = 23'd4;
				near_a = 23'd9;
				width = 12'd1;
			end
			3: begin
				// narrowest legal row, span small enough to clamp both ways
				smax = 15'd4096;
				smin = 16'hF000;
				tmax = 15'd4096;
				far_a = 23'd20;
				near_a = 23'd2;
				width = 12'd2;
			end
			default: begin
				smax = 15'($urandom());
				tmax = 15'($urandom());
				smin = ($urandom_range(0, 1) == 0) ? 16'($urandom())
					: 16'($urandom_range(0, 2000) - 1000);
				near_a = 23'($urandom_range(0, 30));
				case ($urandom_range(0, 3))
					0: far_a = 23'($urandom());
					1: far_a = 23'($urandom_range(0, 30));
					default: far_a = near_a + 23'($urandom_range(1, 40));
				endcase
				width = ($urandom_range(0, 4) == 0) ? 12'($urandom())
					: 12'($urandom_range(2, 20));
			end
		endcase
		write_settings(smax, smin, tmax, far_a, near_a, width);
	endtask

	initial begin : stimulus
		int len;
		int pct;
		int taken;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset settings
		send_word(8'd0, 8'd0, 8'd0, 1'b1);         // lone black pixel: nothing seen
		send_word(8'd255, 8'd255, 8'd255, 1'b1);   // lone white pixel at column 0
		send_word(8'd255, 8'd255, 8'd254, 1'b0);   // red one down: still white
		send_word(8'd255, 8'd255, 8'd253, 1'b0);   // red two down: gray 254, dark
		send_word(8'd251, 8'd255, 8'd255, 1'b0);   // blue four down: white
		send_word(8'd250, 8'd255, 8'd255, 1'b0);   // blue five down: dark
		send_word(8'd255, 8'd254, 8'd255, 1'b0);   // green one down: dark
		send_word(8'd255, 8'd255, 8'd255, 1'b0);
		send_word(8'd0, 8'd255, 8'd0, 1'b0);
		send_word(8'd255, 8'd0, 8'd255, 1'b0);
		send_word(8'd255, 8'd255, 8'd255, 1'b1);
		drain();

		// random frames under a run of settings; every drain is a full pause
		for (int p = 0; p < PHASES; p++) begin
			phase_settings(p);
			tx_burst = (p % 3 == 1);
			if (p == SQUEEZE_PHASE)
				squeeze <= 1'b1;
			taken = 0;
			while (taken < PHASE_WORDS) begin
				if (p == SQUEEZE_PHASE)
					len = $urandom_range(1, 6);
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(17, 64);
				else
					len = $urandom_range(1, 16);
				pct = 25 * $urandom_range(0, 4);
				send_frame(len, pct);
				taken += len;
			end
			drain();
		end

		$display("run covered %0d pixel words in %0d frames under %0d register settings",
			words_sent, frames_sent, settings_applied);
		$display("%0d result words taken, one receiver hold-off of %0d cycles",
			results_taken, SQUEEZE_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
